// ===== src/uat_pkg.sv =====
// ----------------------------------------------------------------------------
// uat_pkg: shared types and codes of the associative table
// Command codes, the decoded command class and the queue payloads.
// ----------------------------------------------------------------------------
package uat_pkg;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_WRITE  = 3'd2;
	localparam logic [2:0] CMD_FIND   = 3'd3;
	localparam logic [2:0] CMD_ERASE  = 3'd4;

	typedef struct packed {
		logic creates;
		logic zero_fill;
		logic is_write;
		logic is_erase;
	} cmd_class_t;

	typedef struct packed {
		cmd_class_t  cls;
		logic [31:0] key;
		logic [31:0] value;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  position;
		logic [31:0] read_value;
		logic [5:0]  entry_count;
		logic        status;
	} res_t;

endpackage

// ===== src/uat_front.sv =====
// ----------------------------------------------------------------------------
// uat_front: request intake
// Decodes each command into its class and holds up to two requests for the
// table engine.
// ----------------------------------------------------------------------------
module uat_front
	import uat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  command,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output item_t       item,
	output logic        item_avail,
	input  logic        item_take
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_class_t cls;
	logic       do_push;

	always_comb begin
		cls = '0;
		case (command)
			CMD_INSERT: begin
				cls.creates = 1'b1;
			end
			CMD_READ: begin
				cls.creates   = 1'b1;
				cls.zero_fill = 1'b1;
			end
			CMD_WRITE: begin
				cls.creates  = 1'b1;
				cls.is_write = 1'b1;
			end
			CMD_ERASE: begin
				cls.is_erase = 1'b1;
			end
			CMD_FIND: begin
				cls = '0;
			end
			// unused codes behave as find
			default: begin
				cls = '0;
			end
		endcase
	end

	assign full       = (cnt_q == 2'd2);
	assign do_push    = push && !full;
	assign item_avail = (cnt_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (item_take) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !item_take) cnt_q <= cnt_q + 2'd1;
			else if (!do_push && item_take) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= '{cls: cls, key: key, value: value};
		end
	end

endmodule

// ===== src/uat_back.sv =====
// ----------------------------------------------------------------------------
// uat_back: table engine
// Compares the key against all live entries, then carries out the command:
// update, append, or erase with a shift down of later entries.
// ----------------------------------------------------------------------------
module uat_back
	import uat_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  item_t item,
	input  logic  item_avail,
	output logic  item_take,
	output res_t  res,
	output logic  res_push,
	input  logic  res_full
);

	localparam int KS = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic ST_CMP = 1'b0;
	localparam logic ST_EXE = 1'b1;

	logic [KS-1:0]       key_q [CAPACITY];
	logic [VS-1:0]       val_q [CAPACITY];
	logic [CW-1:0]       count_q;
	logic                state_q;

	logic [CAPACITY-1:0] hit_s1;
	cmd_class_t          cls_s1;
	logic [KS-1:0]       key_s1;
	logic [VS-1:0]       value_s1;

	logic [CAPACITY-1:0] match;
	logic                exe;
	logic                hit;
	logic [IW-1:0]       pos;
	logic [CW-1:0]       pos_c;
	logic                tbl_full;
	logic                append;
	logic [VS-1:0]       new_val;
	logic [VS-1:0]       rv;
	logic [CW-1:0]       count_nx;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CW'(i) < count_q) && (key_q[i] == item.key[KS-1:0]);
		end
	end

	assign item_take = (state_q == ST_CMP) && item_avail;
	assign exe       = (state_q == ST_EXE) && !res_full;
	assign res_push  = exe;

	// first matching entry wins
	always_comb begin
		pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hit_s1[i]) pos = IW'(i);
		end
	end

	always_comb begin
		hit      = |hit_s1;
		pos_c    = hit ? CW'(pos) : count_q;
		tbl_full = (count_q == CW'(CAPACITY));
		append   = !hit && cls_s1.creates && !tbl_full;
		new_val  = cls_s1.zero_fill ? '0 : value_s1;
		if (hit && !cls_s1.is_erase) rv = cls_s1.is_write ? value_s1 : val_q[pos];
		else if (append) rv = new_val;
		else rv = '0;
		if (hit && cls_s1.is_erase) count_nx = count_q - CW'(1);
		else if (append) count_nx = count_q + CW'(1);
		else count_nx = count_q;
		res.found       = hit;
		res.position    = 6'(pos_c);
		res.read_value  = 32'(rv);
		res.entry_count = 6'(count_nx);
		res.status      = !hit && cls_s1.creates && tbl_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CMP;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_CMP: begin
					if (item_avail) state_q <= ST_EXE;
				end
				ST_EXE: begin
					if (!res_full) begin
						state_q <= ST_CMP;
						count_q <= count_nx;
					end
				end
				default: begin
					state_q <= ST_CMP;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			hit_s1   <= match;
			cls_s1   <= item.cls;
			key_s1   <= item.key[KS-1:0];
			value_s1 <= item.value[VS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (exe) begin
			if (hit && cls_s1.is_write) val_q[pos] <= value_s1;
			// close the gap left by an erased entry
			if (hit && cls_s1.is_erase) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (IW'(i) >= pos) begin
						key_q[i] <= key_q[i+1];
						val_q[i] <= val_q[i+1];
					end
				end
			end
			if (append) begin
				key_q[count_q[IW-1:0]] <= key_s1;
				val_q[count_q[IW-1:0]] <= new_val;
			end
		end
	end

endmodule

// ===== src/uat_res_q.sv =====
// ----------------------------------------------------------------------------
// uat_res_q: result queue
// Two-entry queue that holds results until the consumer pops them.
// ----------------------------------------------------------------------------
module uat_res_q
	import uat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  res_t        res,
	input  logic        res_push,
	output logic        res_full,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [5:0]  position,
	output logic [31:0] read_value,
	output logic [5:0]  entry_count,
	output logic        status
);

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;
	res_t       head;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_pop   = pop && !empty;
	assign head     = slot_q[rd_ptr_q];

	assign found       = head.found;
	assign position    = head.position;
	assign read_value  = head.read_value;
	assign entry_count = head.entry_count;
	assign status      = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (res_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (res_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (!res_push && do_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) slot_q[wr_ptr_q] <= res;
	end

endmodule

// ===== src/unsorted_assoc_table.sv =====
// ----------------------------------------------------------------------------
// unsorted_assoc_table: key/value table kept in insertion order
// Insert, read-or-create, write-or-create, find and erase on a fixed
// capacity table, one result per request.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   push / full        command, key, value
//  result    empty / pop        found, position, read_value, entry_count, status
//
// the engine takes each request in two steps, the parallel key compare and then
// the update or erase shift, and takes no new request until the shift is done
// reset clears the entry count and both queues; no clearing pass is needed
// a two-entry queue on each side lets intake and result delivery stall apart
// ----------------------------------------------------------------------------
module unsorted_assoc_table
	import uat_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  command,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [5:0]  position,
	output logic [31:0] read_value,
	output logic [5:0]  entry_count,
	output logic        status
);

	item_t item;
	logic  item_avail;
	logic  item_take;
	res_t  res;
	logic  res_push;
	logic  res_full;

	uat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.key        (key),
		.value      (value),
		.item       (item),
		.item_avail (item_avail),
		.item_take  (item_take)
	);

	uat_back #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_avail (item_avail),
		.item_take  (item_take),
		.res        (res),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	uat_res_q u_res_q (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.res_push    (res_push),
		.res_full    (res_full),
		.empty       (empty),
		.pop         (pop),
		.found       (found),
		.position    (position),
		.read_value  (read_value),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule
